// ===== rtl/voxel_grid_index_unit_assert.svh =====
// Assertion macros for the voxel grid index unit.
// Used by the controller; expects clk and arst_n in the enclosing scope.
`ifndef VOXEL_GRID_INDEX_UNIT_ASSERT_SVH
`define VOXEL_GRID_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VGI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VGI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VGI_ASSERT_NOW(lbl, ante, cons, msg)
`define VGI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/vgi_pkg.sv =====
// Package for the voxel grid index unit: payload types, codes, helpers.
// No dependencies.
package vgi_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int FX            = 2 * FRAC_BITS;
	localparam int MAX_CELLS     = 16777216;
	localparam int MAX_NEIGHBORS = 27;
	localparam int TOT_W         = $clog2(MAX_CELLS + 1);
	localparam int IDX_W         = 24;
	localparam int SLOT_W        = 5;
	localparam int MUL_W         = 32;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int SPAN_W        = 56;
	localparam int REC_W         = SPAN_W + 2;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_VOLUME = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_POINT  = 2'd3;

	localparam logic [1:0] KIND_VOLUME   = 2'd0;
	localparam logic [1:0] KIND_NEIGHBOR = 2'd1;
	localparam logic [1:0] KIND_POINT    = 2'd2;

	localparam logic [1:0] MODE_CENTER = 2'd0;
	localparam logic [1:0] MODE_FACES  = 2'd1;
	localparam logic [1:0] MODE_CUBE   = 2'd2;

	localparam logic [1:0] REG_LEAF = 2'd0;
	localparam logic [1:0] REG_INV  = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam logic [4:0] OP_NONE  = 5'd0;
	localparam logic [4:0] OP_BOX   = 5'd1;
	localparam logic [4:0] OP_MEXT  = 5'd2;
	localparam logic [4:0] OP_DIM   = 5'd3;
	localparam logic [4:0] OP_MT01  = 5'd4;
	localparam logic [4:0] OP_CHK1  = 5'd5;
	localparam logic [4:0] OP_MT2   = 5'd6;
	localparam logic [4:0] OP_CHK2  = 5'd7;
	localparam logic [4:0] OP_MSPAN = 5'd8;
	localparam logic [4:0] OP_REC   = 5'd9;
	localparam logic [4:0] OP_MSTR  = 5'd10;
	localparam logic [4:0] OP_VEMIT = 5'd11;
	localparam logic [4:0] OP_PSET  = 5'd12;
	localparam logic [4:0] OP_PMUL  = 5'd13;
	localparam logic [4:0] OP_PID   = 5'd14;
	localparam logic [4:0] OP_PMX   = 5'd15;
	localparam logic [4:0] OP_PACC0 = 5'd16;
	localparam logic [4:0] OP_PMY   = 5'd17;
	localparam logic [4:0] OP_PACC1 = 5'd18;
	localparam logic [4:0] OP_PEMIT = 5'd19;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} vgi_req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  cell_index;
		logic [TOT_W-1:0]  total_cells;
		logic              in_bounds;
		logic              volume_error;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} vgi_rsp_t;

	typedef struct packed {
		logic              latch;
		logic [4:0]        op;
		logic [1:0]        axis;
		logic [SLOT_W-1:0] slot;
	} vgi_cmd_t;

	typedef struct packed {
		logic bad;
		logic skip;
		logic last;
	} vgi_sts_t;

	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] pos;
	} vgi_ofs_t;

	function automatic logic [SLOT_W-1:0] vgi_count(input logic [1:0] mode);
		logic [SLOT_W-1:0] c;
		case (mode)
			MODE_FACES: c = SLOT_W'(7);
			MODE_CUBE:  c = SLOT_W'(27);
			default:    c = SLOT_W'(1);
		endcase
		if (c > SLOT_W'(MAX_NEIGHBORS))
			c = SLOT_W'(MAX_NEIGHBORS);
		return c;
	endfunction

	function automatic vgi_ofs_t vgi_offset(input logic [1:0] mode,
		input logic [SLOT_W-1:0] slot);
		vgi_ofs_t o;
		logic [SLOT_W-1:0] r;
		o = '0;
		r = slot;
		case (mode)
			MODE_FACES: begin
				case (slot)
					5'd0:    o.neg[0] = 1'b1;
					5'd1:    o.neg[1] = 1'b1;
					5'd2:    o.neg[2] = 1'b1;
					5'd4:    o.pos[0] = 1'b1;
					5'd5:    o.pos[1] = 1'b1;
					5'd6:    o.pos[2] = 1'b1;
					default: o = '0;
				endcase
			end
			MODE_CUBE: begin
				if (r >= 5'd18) begin
					o.pos[0] = 1'b1;
					r = r - 5'd18;
				end else if (r >= 5'd9) begin
					r = r - 5'd9;
				end else begin
					o.neg[0] = 1'b1;
				end
				if (r >= 5'd6) begin
					o.pos[1] = 1'b1;
					r = r - 5'd6;
				end else if (r >= 5'd3) begin
					r = r - 5'd3;
				end else begin
					o.neg[1] = 1'b1;
				end
				if (r == 5'd2)
					o.pos[2] = 1'b1;
				else if (r == 5'd0)
					o.neg[2] = 1'b1;
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic logic signed [31:0] vgi_sat32(input logic signed [REC_W-1:0] v);
		logic signed [31:0] s;
		if ((&v[REC_W-1:31]) || !(|v[REC_W-1:31]))
			s = v[31:0];
		else if (v[REC_W-1])
			s = 32'sh80000000;
		else
			s = 32'sh7FFFFFFF;
		return s;
	endfunction

endpackage

// ===== rtl/voxel_grid_index_unit.sv =====
// Voxel grid index unit, top level: ties the controller to the datapath.
// Depends on vgi_pkg, vgi_ctrl and vgi_dp.
// One request is worked at a time; results leave through a one-entry output
// register so the next probe proceeds while a result waits. All arithmetic
// shares one 32x32 multiplier; a probe inside the box takes five multiplies.
// A neighbour query gives up to 27 results.
module voxel_grid_index_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [30:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  vgi_pkg::vgi_req_t in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output vgi_pkg::vgi_rsp_t out_rsp
);
	import vgi_pkg::*;

	vgi_cmd_t cmd;
	vgi_sts_t sts;

	vgi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_req.action),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	vgi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_req    (in_req),
		.cmd       (cmd),
		.sts       (sts),
		.out_rsp   (out_rsp)
	);

endmodule

// ===== rtl/vgi_dp.sv =====
// Datapath: config registers, box and grid state, shared 32x32 multiplier,
// probe and cell index arithmetic, result register. Depends on vgi_pkg.
module vgi_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [30:0]      cfg_data,
	input  vgi_pkg::vgi_req_t in_req,
	input  vgi_pkg::vgi_cmd_t cmd,
	output vgi_pkg::vgi_sts_t sts,
	output vgi_pkg::vgi_rsp_t out_rsp
);
	import vgi_pkg::*;

	logic [30:0]        leaf_q;
	logic [30:0]        inv_q;
	logic [1:0]         mode_q;
	logic signed [31:0] box_lo_q [3];
	logic signed [31:0] box_hi_q [3];
	logic               any_q;
	logic [TOT_W-1:0]   dims_q [3];
	logic [TOT_W-1:0]   stride_q;
	logic               ready_q;

	logic [1:0]         act_q;
	logic signed [31:0] pos_q [3];
	logic signed [33:0] p_q [3];
	logic               inb_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MUL_W-1:0]   dimn_q [3];
	logic               bad_q;
	logic [TOT_W-1:0]   tot_q;
	logic [IDX_W-1:0]   id_q [3];
	logic [IDX_W-1:0]   acc_q;
	vgi_rsp_t           out_q;

	logic [1:0]            ax;
	logic [MUL_W-1:0]      ext;
	logic signed [34:0]    dlt;
	logic [MUL_W-1:0]      ud;
	logic [MUL_W-1:0]      mul_a;
	logic [MUL_W-1:0]      mul_b;
	logic [PROD_W-1:0]     mul_p;
	logic [PROD_W:0]       dsum;
	logic [PROD_W-FX:0]    dimv;
	logic                  dim_bad;
	logic signed [REC_W-1:0] span;
	logic signed [REC_W-1:0] rsum;
	logic signed [REC_W-1:0] rlo;
	logic signed [REC_W-1:0] rhi;
	logic [MUL_W-1:0]      idv;
	logic [TOT_W-1:0]      dm1;
	logic [IDX_W-1:0]      idc;
	vgi_ofs_t              ofs;
	logic [1:0]            mode_eff;
	logic signed [33:0]    lf;
	logic signed [33:0]    pr [3];
	logic                  in_box;
	logic                  last;
	logic                  cell_ok;

	assign ax = cmd.axis;
	assign ext = MUL_W'(box_hi_q[ax] - box_lo_q[ax]);
	assign dlt = 35'(p_q[ax]) - 35'(box_lo_q[ax]);

	always_comb begin
		if (dlt <= 35'sd0)
			ud = '0;
		else if (|dlt[34:MUL_W])
			ud = '1;
		else
			ud = dlt[MUL_W-1:0];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MEXT: begin
				mul_a = ext;
				mul_b = MUL_W'(inv_q);
			end
			OP_MT01: begin
				mul_a = dimn_q[0];
				mul_b = dimn_q[1];
			end
			OP_MT2: begin
				mul_a = MUL_W'(tot_q);
				mul_b = dimn_q[2];
			end
			OP_MSPAN: begin
				mul_a = dimn_q[ax];
				mul_b = MUL_W'(leaf_q);
			end
			OP_MSTR: begin
				mul_a = dimn_q[1];
				mul_b = dimn_q[2];
			end
			OP_PMUL: begin
				mul_a = ud;
				mul_b = MUL_W'(inv_q);
			end
			OP_PMX: begin
				mul_a = MUL_W'(id_q[0]);
				mul_b = MUL_W'(stride_q);
			end
			OP_PMY: begin
				mul_a = MUL_W'(id_q[1]);
				mul_b = MUL_W'(dims_q[2]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ceil of the product down to whole cells
	assign dsum = {1'b0, prod_q} + (PROD_W + 1)'((64'd1 << FX) - 64'd1);
	assign dimv = dsum[PROD_W:FX];
	assign dim_bad = (dimv == '0) || (dimv > (PROD_W - FX + 1)'(MAX_CELLS));

	// recentre: lo = floor((low + high - span) / 2)
	assign span = $signed({2'b00, prod_q[SPAN_W-1:0]});
	assign rsum = REC_W'(box_lo_q[ax]) + REC_W'(box_hi_q[ax]) - span;
	assign rlo = rsum >>> 1;
	assign rhi = rlo + span;

	assign idv = prod_q[PROD_W-1:FX];
	assign dm1 = dims_q[ax] - TOT_W'(1);
	assign idc = (idv > MUL_W'(dm1)) ? dm1[IDX_W-1:0] : idv[IDX_W-1:0];

	assign mode_eff = (act_q == ACT_POINT) ? MODE_CENTER : mode_q;
	assign ofs = vgi_offset(mode_eff, cmd.slot);
	assign lf = $signed({3'b000, leaf_q});

	always_comb begin
		in_box = 1'b1;
		for (int a = 0; a < 3; a++) begin
			pr[a] = 34'(pos_q[a]) + (ofs.pos[a] ? lf : (ofs.neg[a] ? -lf : 34'sd0));
			if (pr[a] <= 34'(box_lo_q[a]) || pr[a] >= 34'(box_hi_q[a]))
				in_box = 1'b0;
		end
	end

	assign last = (act_q == ACT_POINT) || (cmd.slot == vgi_count(mode_q) - SLOT_W'(1));
	assign cell_ok = (act_q == ACT_QUERY) ? inb_q : ready_q;

	assign sts.bad = bad_q;
	assign sts.skip = (act_q == ACT_QUERY) ? !inb_q : !ready_q;
	assign sts.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q <= 31'd65536;
			inv_q <= 31'd65536;
			mode_q <= MODE_CENTER;
			any_q <= 1'b0;
			stride_q <= '0;
			ready_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				box_lo_q[a] <= '0;
				box_hi_q[a] <= '0;
				dims_q[a] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEAF: leaf_q <= cfg_data;
					REG_INV:  inv_q <= cfg_data;
					REG_MODE: mode_q <= cfg_data[1:0];
					default:  ;
				endcase
			end
			case (cmd.op)
				OP_BOX: begin
					for (int a = 0; a < 3; a++) begin
						if (!any_q || pos_q[a] < box_lo_q[a])
							box_lo_q[a] <= pos_q[a];
						if (!any_q || pos_q[a] > box_hi_q[a])
							box_hi_q[a] <= pos_q[a];
					end
					any_q <= 1'b1;
				end
				OP_REC: begin
					box_lo_q[ax] <= vgi_sat32(rlo);
					box_hi_q[ax] <= vgi_sat32(rhi);
					dims_q[ax] <= dimn_q[ax][TOT_W-1:0];
				end
				OP_VEMIT: begin
					ready_q <= !bad_q;
					if (!bad_q)
						stride_q <= prod_q[TOT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= in_req.action;
			pos_q[0] <= in_req.pos_x;
			pos_q[1] <= in_req.pos_y;
			pos_q[2] <= in_req.pos_z;
		end
		case (cmd.op)
			OP_MEXT, OP_MT01, OP_MT2, OP_MSPAN, OP_MSTR, OP_PMUL, OP_PMX, OP_PMY:
				prod_q <= mul_p;
			OP_DIM: begin
				dimn_q[ax] <= dimv[MUL_W-1:0];
				bad_q <= ((ax == 2'd0) ? !any_q : bad_q) || dim_bad;
			end
			OP_CHK1, OP_CHK2: begin
				if (prod_q > PROD_W'(MAX_CELLS))
					bad_q <= 1'b1;
				tot_q <= prod_q[TOT_W-1:0];
			end
			OP_VEMIT: begin
				out_q.kind <= KIND_VOLUME;
				out_q.cell_index <= '0;
				out_q.total_cells <= bad_q ? '0 : tot_q;
				out_q.in_bounds <= 1'b0;
				out_q.volume_error <= bad_q;
				out_q.slot <= '0;
				out_q.last <= 1'b1;
			end
			OP_PSET: begin
				for (int a = 0; a < 3; a++)
					p_q[a] <= pr[a];
				inb_q <= ready_q && in_box;
			end
			OP_PID: id_q[ax] <= idc;
			OP_PACC0: acc_q <= prod_q[IDX_W-1:0] + id_q[2];
			OP_PACC1: acc_q <= acc_q + prod_q[IDX_W-1:0];
			OP_PEMIT: begin
				out_q.kind <= (act_q == ACT_POINT) ? KIND_POINT : KIND_NEIGHBOR;
				out_q.cell_index <= cell_ok ? acc_q : '0;
				out_q.total_cells <= '0;
				out_q.in_bounds <= inb_q;
				out_q.volume_error <= !ready_q;
				out_q.slot <= (act_q == ACT_POINT) ? '0 : cmd.slot;
				out_q.last <= last;
			end
			default: ;
		endcase
	end

	assign out_rsp = out_q;

endmodule

// ===== rtl/vgi_ctrl.sv =====
// Controller: request handshake, step sequencer, result valid.
// Depends on vgi_pkg and voxel_grid_index_unit_assert.svh.
`include "voxel_grid_index_unit_assert.svh"
module vgi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_action,
	input  logic             out_ready,
	input  vgi_pkg::vgi_sts_t sts,
	output logic             in_ready,
	output logic             out_valid,
	output vgi_pkg::vgi_cmd_t cmd
);
	import vgi_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_BOX   = 5'd1;
	localparam logic [4:0] S_MEXT  = 5'd2;
	localparam logic [4:0] S_DIM   = 5'd3;
	localparam logic [4:0] S_MT01  = 5'd4;
	localparam logic [4:0] S_CHK1  = 5'd5;
	localparam logic [4:0] S_MT2   = 5'd6;
	localparam logic [4:0] S_CHK2  = 5'd7;
	localparam logic [4:0] S_MSPAN = 5'd8;
	localparam logic [4:0] S_REC   = 5'd9;
	localparam logic [4:0] S_MSTR  = 5'd10;
	localparam logic [4:0] S_VEMIT = 5'd11;
	localparam logic [4:0] S_PSET  = 5'd12;
	localparam logic [4:0] S_PMUL  = 5'd13;
	localparam logic [4:0] S_PID   = 5'd14;
	localparam logic [4:0] S_PMX   = 5'd15;
	localparam logic [4:0] S_PACC0 = 5'd16;
	localparam logic [4:0] S_PMY   = 5'd17;
	localparam logic [4:0] S_PACC1 = 5'd18;
	localparam logic [4:0] S_PEMIT = 5'd19;

	logic [4:0]        state_q;
	logic [4:0]        state_d;
	logic [1:0]        ax_q;
	logic [1:0]        ax_d;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_d;
	logic              out_valid_q;
	logic              can_emit;
	logic              emit;

	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ax_d = ax_q;
		slot_d = slot_q;
		emit = 1'b0;
		cmd = '0;
		cmd.axis = ax_q;
		cmd.slot = slot_q;
		cmd.latch = in_valid && in_ready;
		case (state_q)
			S_IDLE: begin
				ax_d = 2'd0;
				slot_d = '0;
				if (in_valid) begin
					case (in_action)
						ACT_LOAD:   state_d = S_BOX;
						ACT_VOLUME: state_d = S_MEXT;
						default:    state_d = S_PSET;
					endcase
				end
			end
			S_BOX: begin
				cmd.op = OP_BOX;
				state_d = S_IDLE;
			end
			S_MEXT: begin
				cmd.op = OP_MEXT;
				state_d = S_DIM;
			end
			S_DIM: begin
				cmd.op = OP_DIM;
				if (ax_q == 2'd2) begin
					state_d = S_MT01;
				end else begin
					ax_d = ax_q + 2'd1;
					state_d = S_MEXT;
				end
			end
			S_MT01: begin
				if (sts.bad) begin
					state_d = S_VEMIT;
				end else begin
					cmd.op = OP_MT01;
					state_d = S_CHK1;
				end
			end
			S_CHK1: begin
				cmd.op = OP_CHK1;
				state_d = S_MT2;
			end
			S_MT2: begin
				if (sts.bad) begin
					state_d = S_VEMIT;
				end else begin
					cmd.op = OP_MT2;
					state_d = S_CHK2;
				end
			end
			S_CHK2: begin
				cmd.op = OP_CHK2;
				ax_d = 2'd0;
				state_d = S_MSPAN;
			end
			S_MSPAN: begin
				if (sts.bad) begin
					state_d = S_VEMIT;
				end else begin
					cmd.op = OP_MSPAN;
					state_d = S_REC;
				end
			end
			S_REC: begin
				cmd.op = OP_REC;
				if (ax_q == 2'd2) begin
					state_d = S_MSTR;
				end else begin
					ax_d = ax_q + 2'd1;
					state_d = S_MSPAN;
				end
			end
			S_MSTR: begin
				cmd.op = OP_MSTR;
				state_d = S_VEMIT;
			end
			S_VEMIT: begin
				if (can_emit) begin
					cmd.op = OP_VEMIT;
					emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PSET: begin
				cmd.op = OP_PSET;
				ax_d = 2'd0;
				state_d = S_PMUL;
			end
			S_PMUL: begin
				if (sts.skip) begin
					state_d = S_PEMIT;
				end else begin
					cmd.op = OP_PMUL;
					state_d = S_PID;
				end
			end
			S_PID: begin
				cmd.op = OP_PID;
				if (ax_q == 2'd2) begin
					state_d = S_PMX;
				end else begin
					ax_d = ax_q + 2'd1;
					state_d = S_PMUL;
				end
			end
			S_PMX: begin
				cmd.op = OP_PMX;
				state_d = S_PACC0;
			end
			S_PACC0: begin
				cmd.op = OP_PACC0;
				state_d = S_PMY;
			end
			S_PMY: begin
				cmd.op = OP_PMY;
				state_d = S_PACC1;
			end
			S_PACC1: begin
				cmd.op = OP_PACC1;
				state_d = S_PEMIT;
			end
			S_PEMIT: begin
				if (can_emit) begin
					cmd.op = OP_PEMIT;
					emit = 1'b1;
					if (sts.last) begin
						state_d = S_IDLE;
					end else begin
						slot_d = slot_q + SLOT_W'(1);
						state_d = S_PSET;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q <= 2'd0;
			slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ax_q <= ax_d;
			slot_q <= slot_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`VGI_ASSERT_NOW(a_slot_range, state_q != S_IDLE, slot_q <= SLOT_W'(MAX_NEIGHBORS - 1), "slot past limit")
	`VGI_ASSERT_NOW(a_axis_range, 1'b1, ax_q != 2'd3, "axis counter out of range")
	`VGI_ASSERT_NEXT(a_probe_start, in_valid && in_ready && in_action == ACT_QUERY, state_q == S_PSET, "query did not start probing")
	`VGI_ASSERT_NEXT(a_emit_hold, out_valid_q && !out_ready, out_valid_q, "result dropped while stalled")

endmodule

// ===== bench/vgi_checker.sv =====
// Checker for the voxel grid index unit: watches the register port and both channels,
// predicts every response and compares it with what the unit returns.
// Depends on vgi_pkg.
`timescale 1ns / 100ps

module vgi_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [30:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  vgi_pkg::vgi_req_t in_req,
	input  logic              out_valid,
	input  logic              out_ready,
	input  vgi_pkg::vgi_rsp_t out_rsp,
	output int                errors,
	output int                pending
);
	import vgi_pkg::*;

	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;

	longint            box_lo[3];
	longint            box_hi[3];
	bit                have_point;
	longint unsigned   dims[3];
	longint unsigned   plane;
	bit                sized;
	longint unsigned   leaf;
	longint unsigned   inv;
	logic [1:0]        mode;
	vgi_rsp_t          rsp_q[$];

	assign pending = rsp_q.size();

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("%0t: %s got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic queue_rsp(input vgi_rsp_t r);
		rsp_q = {rsp_q, r};
	endtask

	function automatic vgi_rsp_t pack_rsp(input logic [1:0] kind, input longint unsigned cell_no,
		input longint unsigned total, input bit inb, input bit err, input int slot,
		input bit last);
		vgi_rsp_t r;
		r.kind         = kind;
		r.cell_index   = cell_no[IDX_W-1:0];
		r.total_cells  = total[TOT_W-1:0];
		r.in_bounds    = inb;
		r.volume_error = err;
		r.slot         = slot[SLOT_W-1:0];
		r.last         = last;
		return r;
	endfunction

	function automatic bit inside_box(input longint p[3]);
		for (int a = 0; a < 3; a++)
			if (p[a] <= box_lo[a] || p[a] >= box_hi[a])
				return 0;
		return 1;
	endfunction

	function automatic longint unsigned cell_number(input longint p[3]);
		longint unsigned idx;
		longint          d;
		longint unsigned ud;
		longint unsigned id;
		idx = 0;
		for (int a = 0; a < 3; a++) begin
			d  = p[a] - box_lo[a];
			id = 0;
			if (d > 0) begin
				ud = d;
				if (ud > 64'hFFFF_FFFF)
					ud = 64'hFFFF_FFFF;
				id = (ud * inv) >> FX;
			end
			if (dims[a] > 0 && id > dims[a] - 1)
				id = dims[a] - 1;
			if (a == 0)
				idx += id * plane;
			else if (a == 1)
				idx += id * dims[2];
			else
				idx += id;
		end
		return idx;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > I32_MAX)
			return I32_MAX;
		if (v < I32_MIN)
			return I32_MIN;
		return v;
	endfunction

	task automatic size_grid();
		longint unsigned nd[3];
		longint unsigned total;
		longint unsigned ext;
		longint          span;
		longint          lo;
		bit              bad;
		bad = !have_point;
		for (int a = 0; a < 3; a++) begin
			ext   = box_hi[a] - box_lo[a];
			nd[a] = (ext * inv + ((64'd1 << FX) - 1)) >> FX;
			if (nd[a] == 0 || nd[a] > MAX_CELLS)
				bad = 1;
		end
		total = 0;
		if (!bad) begin
			total = nd[0] * nd[1];
			if (total > MAX_CELLS)
				bad = 1;
			else begin
				total *= nd[2];
				if (total > MAX_CELLS)
					bad = 1;
			end
		end
		if (bad) begin
			sized = 0;
			queue_rsp(pack_rsp(KIND_VOLUME, 0, 0, 0, 1, 0, 1));
		end else begin
			for (int a = 0; a < 3; a++) begin
				span      = nd[a] * leaf;
				lo        = (box_lo[a] + box_hi[a] - span) >>> 1;
				box_lo[a] = clamp32(lo);
				box_hi[a] = clamp32(lo + span);
				dims[a]   = nd[a];
			end
			plane = nd[1] * nd[2];
			sized = 1;
			queue_rsp(pack_rsp(KIND_VOLUME, 0, total, 0, 0, 0, 1));
		end
	endtask

	task automatic predict(input vgi_req_t r);
		longint          pos[3];
		longint          p[3];
		int              off[3];
		int              count;
		bit              inb;
		longint unsigned cell_no;
		pos[0] = r.pos_x;
		pos[1] = r.pos_y;
		pos[2] = r.pos_z;
		case (r.action)
			ACT_LOAD: begin
				for (int a = 0; a < 3; a++) begin
					if (!have_point || pos[a] < box_lo[a])
						box_lo[a] = pos[a];
					if (!have_point || pos[a] > box_hi[a])
						box_hi[a] = pos[a];
				end
				have_point = 1;
			end
			ACT_VOLUME: size_grid();
			ACT_POINT: begin
				if (!sized)
					queue_rsp(pack_rsp(KIND_POINT, 0, 0, 0, 1, 0, 1));
				else
					queue_rsp(pack_rsp(KIND_POINT, cell_number(pos), 0,
						inside_box(pos), 0, 0, 1));
			end
			default: begin
				count = (mode == MODE_FACES) ? 7 : ((mode == MODE_CUBE) ? 27 : 1);
				if (count > MAX_NEIGHBORS)
					count = MAX_NEIGHBORS;
				for (int s = 0; s < count; s++) begin
					off = '{0, 0, 0};
					if (mode == MODE_CUBE) begin
						off[0] = s / 9 - 1;
						off[1] = (s / 3) % 3 - 1;
						off[2] = s % 3 - 1;
					end else if (mode == MODE_FACES) begin
						if (s < 3)
							off[s] = -1;
						else if (s > 3)
							off[s-4] = 1;
					end
					for (int a = 0; a < 3; a++)
						p[a] = pos[a] + longint'(off[a]) * longint'(leaf);
					inb     = sized && inside_box(p);
					cell_no = inb ? cell_number(p) : 0;
					queue_rsp(pack_rsp(KIND_NEIGHBOR, cell_no, 0, inb, !sized, s,
						s == count - 1));
				end
			end
		endcase
	endtask

	task automatic compare(input vgi_rsp_t got);
		vgi_rsp_t want;
		if (rsp_q.size() == 0) begin
			report("unexpected response, kind", got.kind, -1);
			return;
		end
		want = rsp_q.pop_front();
		if (got.kind !== want.kind)
			report("kind", got.kind, want.kind);
		if (got.cell_index !== want.cell_index)
			report("cell_index", got.cell_index, want.cell_index);
		if (got.total_cells !== want.total_cells)
			report("total_cells", got.total_cells, want.total_cells);
		if (got.in_bounds !== want.in_bounds)
			report("in_bounds", got.in_bounds, want.in_bounds);
		if (got.volume_error !== want.volume_error)
			report("volume_error", got.volume_error, want.volume_error);
		if (got.slot !== want.slot)
			report("slot", got.slot, want.slot);
		if (got.last !== want.last)
			report("last", got.last, want.last);
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo     = '{0, 0, 0};
			box_hi     = '{0, 0, 0};
			have_point = 0;
			dims       = '{0, 0, 0};
			plane      = 0;
			sized      = 0;
			leaf       = 65536;
			inv        = 65536;
			mode       = MODE_CENTER;
			rsp_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEAF: leaf = cfg_data;
					REG_INV:  inv  = cfg_data;
					REG_MODE: mode = cfg_data[1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready)
				compare(out_rsp);
			if (in_valid && in_ready)
				predict(in_req);
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the voxel grid index unit bench: clock, reset, requests and the verdict.
// Depends on vgi_pkg, voxel_grid_index_unit and vgi_checker.
`timescale 1ns / 100ps

module testbench;
	import vgi_pkg::*;

	localparam int LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	vgi_req_t    in_req;
	logic        out_valid;
	logic        out_ready;
	vgi_rsp_t    out_rsp;
	int          errors;
	int          pending;
	int          cycles;
	bit          quiet;
	longint      center[3];
	longint      radius;

	voxel_grid_index_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
	);

	vgi_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		out_ready <= 0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!quiet) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	task automatic send(input logic [1:0] act, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid      <= 1;
		in_req.action <= act;
		in_req.pos_x  <= x;
		in_req.pos_y  <= y;
		in_req.pos_z  <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		drain();
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 0;
	endtask

	function automatic logic [31:0] near(input int a);
		longint off;
		off = longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF;
		off = off % (2 * radius + 1) - radius;
		return 32'(center[a] + off);
	endfunction

	task automatic send_near(input logic [1:0] act);
		send(act, near(0), near(1), near(2));
	endtask

	task automatic run_phase(input longint unsigned leaf_v, input longint unsigned inv_v,
		input logic [1:0] mode_v);
		int n;
		write_reg(REG_LEAF, leaf_v[30:0]);
		write_reg(REG_INV, inv_v[30:0]);
		write_reg(REG_MODE, 31'(mode_v));
		radius = leaf_v * $urandom_range(1, 12);
		if (radius > 64'd1 << 30)
			radius = 64'd1 << 30;
		for (int a = 0; a < 3; a++)
			center[a] = longint'($signed($urandom)) >>> $urandom_range(0, 8);
		n = $urandom_range(2, 5);
		repeat (n) send_near(ACT_LOAD);
		send(ACT_VOLUME, $urandom, $urandom, $urandom);
		repeat (10) begin
			case ($urandom_range(0, 9))
				0:       send(2'($urandom), $urandom, $urandom, $urandom);
				1:       send_near(ACT_LOAD);
				2:       send(ACT_VOLUME, 0, 0, 0);
				3, 4, 5: send_near(ACT_POINT);
				default: send_near(ACT_QUERY);
			endcase
		end
	endtask

	initial begin
		longint unsigned lf;
		longint unsigned iv;
		arst_n    <= 0;
		cfg_we    <= 0;
		cfg_index <= REG_LEAF;
		cfg_data  <= '0;
		in_valid  <= 0;
		in_req    <= '0;
		cycles    = 0;
		quiet     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// no grid, no points, single point with zero extent
		send(ACT_QUERY, 0, 0, 0);
		send(ACT_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send(ACT_VOLUME, 0, 0, 0);
		send(ACT_LOAD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		send(ACT_VOLUME, 0, 0, 0);
		send(ACT_LOAD, 32'h0005_8000, 32'h0004_0000, 32'h0007_4000);
		send(ACT_VOLUME, 0, 0, 0);
		send(ACT_QUERY, 32'h0003_0000, 32'h0003_0000, 32'h0005_0000);
		send(ACT_POINT, 32'h0003_0000, 32'h0003_0000, 32'h0005_0000);
		send(ACT_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(ACT_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		write_reg(REG_MODE, 31'(MODE_FACES));
		send(ACT_QUERY, 32'h0003_0000, 32'h0003_0000, 32'h0005_0000);
		write_reg(REG_MODE, 31'(MODE_CUBE));
		send(ACT_QUERY, 32'h0003_0000, 32'h0003_0000, 32'h0005_0000);
		write_reg(REG_MODE, 31'd3);
		send(ACT_QUERY, 32'h0003_0000, 32'h0003_0000, 32'h0005_0000);
		// box at the coordinate extremes: too many cells, then saturation
		send(ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(ACT_VOLUME, 0, 0, 0);
		write_reg(REG_LEAF, 31'h7FFF_FFFF);
		write_reg(REG_INV, 31'd2);
		send(ACT_VOLUME, 0, 0, 0);
		write_reg(REG_MODE, 31'(MODE_CUBE));
		send(ACT_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send(ACT_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 0);

		for (int ph = 0; ph < 13; ph++) begin
			if (ph == 10)
				quiet = 1;
			case (ph)
				0:       begin lf = 65536;      iv = 65536; end
				1:       begin lf = 1;          iv = 31'h7FFF_FFFF; end
				2:       begin lf = 31'h7FFF_FFFF; iv = 1; end
				3:       begin lf = 31'h7FFF_FFFF; iv = 2; end
				default: begin
					lf = $urandom_range(1 << 10, 1 << 22);
					iv = (64'd1 << 32) / lf;
					if ($urandom_range(0, 3) == 0)
						iv = iv + $urandom_range(0, 64) - 32;
					if (iv > 31'h7FFF_FFFF)
						iv = 31'h7FFF_FFFF;
					if (iv < 1)
						iv = 1;
				end
			endcase
			run_phase(lf, iv, 2'(ph % 4));
		end

		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
